>>> src/sga_pkg.sv
package sga_pkg;

   localparam int SLABS_PER_GROUP = 64;
   localparam int NUM_GROUPS      = 16;

   localparam int GRP_W     = 4;
   localparam int SLAB_W    = 6;
   localparam int CNT_W     = $clog2(SLABS_PER_GROUP + 1);
   localparam int STATUS_W  = 2;
   localparam int QPTR_W    = $clog2(NUM_GROUPS) + 1;
   localparam int LINK_AW   = GRP_W + SLAB_W;
   localparam int LINK_SIZE = NUM_GROUPS * SLABS_PER_GROUP;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_CAP  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_REL = 2'd2;

   typedef struct packed {
      logic              kind;
      logic [GRP_W-1:0]  group_id;
      logic [SLAB_W-1:0] slab_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [GRP_W-1:0]    grant_group;
      logic [SLAB_W-1:0]   grant_slab;
      logic [CNT_W-1:0]    group_free_left;
   } rsp_type;

   // Per-group bookkeeping. A head equal to SLABS_PER_GROUP means the top of
   // the free stack lies in the never-issued region below fresh.
   typedef struct packed {
      logic [CNT_W-1:0] head;
      logic [CNT_W-1:0] fresh;
      logic [CNT_W-1:0] count;
   } grp_entry_type;

endpackage

>>> src/slab_group_allocator.sv
// A release passes through FSM_REL; an allocate finishes in FSM_IDLE when a spare group
// is opened, and passes through FSM_QWAIT and FSM_GRP when it takes a queued group, with
// FSM_GRP2 to retire a wholly free group and FSM_LINK to read the slab link. The result is
// registered. Throughput: one item at a time, limited by the dependent reads of the group
// table and the slab link memory. Reset clears the control state, the live flags and the
// queue pointers; the memories keep no reset. The receiver cannot stall the result strobe.
module slab_group_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sga_pkg::req_type req_data,
   output logic             rsp_valid,
   output sga_pkg::rsp_type rsp_data
);
   import sga_pkg::*;

   typedef enum logic [5:0] {
      FSM_IDLE  = 6'b000001,
      FSM_QWAIT = 6'b000010,
      FSM_GRP   = 6'b000100,
      FSM_GRP2  = 6'b001000,
      FSM_LINK  = 6'b010000,
      FSM_REL   = 6'b100000
   } fsm_type;

   fsm_type state_ff, state_in;

   logic [GRP_W-1:0]      g_ff, g_in;
   logic [SLAB_W-1:0]     s_ff, s_in;
   grp_entry_type         cur_ff, cur_in;
   logic [NUM_GROUPS-1:0] live_ff, live_in;
   logic [QPTR_W-1:0]     q_head_ff, q_head_in;
   logic [QPTR_W-1:0]     q_tail_ff, q_tail_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // Memories.
   grp_entry_type         grp_mem [NUM_GROUPS];
   logic [CNT_W-1:0]      link_mem [LINK_SIZE];
   logic [GRP_W-1:0]      q_mem [NUM_GROUPS];

   grp_entry_type         grp_rd_ff;
   logic [CNT_W-1:0]      link_rd_ff;
   logic [GRP_W-1:0]      q_rd_ff;

   logic [GRP_W-1:0]      grp_raddr;
   logic                  grp_we;
   logic [GRP_W-1:0]      grp_waddr;
   grp_entry_type         grp_wdata;
   logic [LINK_AW-1:0]    link_raddr;
   logic                  link_we;
   logic [LINK_AW-1:0]    link_waddr;
   logic [CNT_W-1:0]      link_wdata;
   logic                  q_we;
   logic [GRP_W-1:0]      q_wdata;

   logic [QPTR_W-1:0]     q_used;
   logic                  q_empty;
   logic                  q_full;

   logic                  open_found;
   logic [GRP_W-1:0]      open_g;

   // Completion of a take: the updated group entry and the granted slab.
   logic                  fin;
   logic [GRP_W-1:0]      fin_g;
   logic [SLAB_W-1:0]     fin_s;
   grp_entry_type         fin_entry;
   logic                  push_req;
   logic [GRP_W-1:0]      push_g;

   assign q_used  = q_tail_ff - q_head_ff;
   assign q_empty = (q_used == '0);
   assign q_full  = (q_used >= QPTR_W'(NUM_GROUPS));

   // Lowest-numbered spare group.
   always_comb begin
      open_found = 1'b0;
      open_g     = '0;
      for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            open_found = 1'b1;
            open_g     = GRP_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      g_in         = g_ff;
      s_in         = s_ff;
      cur_in       = cur_ff;
      live_in      = live_ff;
      q_head_in    = q_head_ff;
      q_tail_in    = q_tail_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      grp_raddr    = g_ff;
      grp_we       = 1'b0;
      grp_waddr    = g_ff;
      grp_wdata    = grp_rd_ff;
      link_raddr   = {g_ff, s_ff};
      link_we      = 1'b0;
      link_waddr   = {g_ff, s_ff};
      link_wdata   = grp_rd_ff.head;
      q_we         = 1'b0;
      q_wdata      = g_ff;
      fin          = 1'b0;
      fin_g        = g_ff;
      fin_s        = '0;
      fin_entry    = grp_rd_ff;
      push_req     = 1'b0;
      push_g       = g_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               if (req_data.kind == KIND_RELEASE) begin
                  g_in      = req_data.group_id;
                  s_in      = req_data.slab_index;
                  grp_raddr = req_data.group_id;
                  state_in  = FSM_REL;
               end else if (!q_empty) begin
                  q_head_in = q_head_ff + 1'b1;
                  state_in  = FSM_QWAIT;
               end else if (open_found) begin
                  // Open a spare group and issue its highest slab at once.
                  live_in[open_g] = 1'b1;
                  fin             = 1'b1;
                  fin_g           = open_g;
                  fin_s           = SLAB_W'(SLABS_PER_GROUP - 1);
                  fin_entry.head  = CNT_W'(SLABS_PER_GROUP);
                  fin_entry.fresh = CNT_W'(SLABS_PER_GROUP - 1);
                  fin_entry.count = CNT_W'(SLABS_PER_GROUP - 1);
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = STATUS_NO_CAP;
               end
            end
         end
         FSM_QWAIT: begin
            g_in      = q_rd_ff;
            grp_raddr = q_rd_ff;
            state_in  = FSM_GRP;
         end
         FSM_GRP, FSM_GRP2: begin
            if (state_ff == FSM_GRP && grp_rd_ff.count == CNT_W'(SLABS_PER_GROUP)
                && !q_empty) begin
               // Wholly free group with another one queued: retire it.
               live_in[g_ff] = 1'b0;
               g_in          = q_rd_ff;
               grp_raddr     = q_rd_ff;
               q_head_in     = q_head_ff + 1'b1;
               state_in      = FSM_GRP2;
            end else if (grp_rd_ff.count == '0
                         || grp_rd_ff.fresh > CNT_W'(SLABS_PER_GROUP)) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = STATUS_NO_CAP;
               state_in           = FSM_IDLE;
            end else if (grp_rd_ff.head < CNT_W'(SLABS_PER_GROUP)) begin
               s_in       = grp_rd_ff.head[SLAB_W-1:0];
               cur_in     = grp_rd_ff;
               link_raddr = {g_ff, grp_rd_ff.head[SLAB_W-1:0]};
               state_in   = FSM_LINK;
            end else begin
               fin             = 1'b1;
               fin_s           = SLAB_W'(grp_rd_ff.fresh - 1'b1);
               fin_entry.fresh = grp_rd_ff.fresh - 1'b1;
               fin_entry.count = grp_rd_ff.count - 1'b1;
               state_in        = FSM_IDLE;
            end
         end
         FSM_LINK: begin
            fin             = 1'b1;
            fin_s           = s_ff;
            fin_entry       = cur_ff;
            fin_entry.head  = link_rd_ff;
            fin_entry.count = cur_ff.count - 1'b1;
            state_in        = FSM_IDLE;
         end
         FSM_REL: begin
            rsp_valid_in = 1'b1;
            state_in     = FSM_IDLE;
            if (CNT_W'(s_ff) >= CNT_W'(SLABS_PER_GROUP) || !live_ff[g_ff]) begin
               rsp_data_in.status = STATUS_BAD_REL;
            end else if (grp_rd_ff.count >= CNT_W'(SLABS_PER_GROUP)) begin
               rsp_data_in.status          = STATUS_BAD_REL;
               rsp_data_in.group_free_left = grp_rd_ff.count;
            end else begin
               link_we         = 1'b1;
               link_wdata      = grp_rd_ff.head;
               grp_we          = 1'b1;
               grp_wdata.head  = CNT_W'(s_ff);
               grp_wdata.count = grp_rd_ff.count + 1'b1;
               push_req        = (grp_rd_ff.count == '0);
               rsp_data_in.status          = STATUS_OK;
               rsp_data_in.group_free_left = grp_rd_ff.count + 1'b1;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      if (fin) begin
         grp_we       = 1'b1;
         grp_waddr    = fin_g;
         grp_wdata    = fin_entry;
         push_req     = (fin_entry.count != '0);
         push_g       = fin_g;
         rsp_valid_in = 1'b1;
         rsp_data_in.status          = STATUS_OK;
         rsp_data_in.grant_group     = fin_g;
         rsp_data_in.grant_slab      = fin_s;
         rsp_data_in.group_free_left = fin_entry.count;
      end

      // A group is queued at most once, so the full check never drops an append.
      if (push_req && !q_full) begin
         q_we      = 1'b1;
         q_wdata   = push_g;
         q_tail_in = q_tail_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         live_ff      <= '0;
         q_head_ff    <= '0;
         q_tail_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         q_head_ff    <= q_head_in;
         q_tail_ff    <= q_tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff        <= g_in;
      s_ff        <= s_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (grp_we) begin
         grp_mem[grp_waddr] <= grp_wdata;
      end
      grp_rd_ff <= grp_mem[grp_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   // The queue head is read every cycle so that a popped group is ready in the next cycle.
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_tail_ff[GRP_W-1:0]] <= q_wdata;
      end
      q_rd_ff <= q_mem[q_head_ff[GRP_W-1:0]];
   end

   assign busy      = (state_ff != FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_used <= QPTR_W'(NUM_GROUPS))
      else $error("free-group queue holds more entries than groups");

   a_link_has_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_LINK |-> cur_ff.count != '0)
      else $error("slab link followed in a group without free slabs");

   a_retire_needs_queue: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_GRP2 |-> $past(q_head_ff) != $past(q_tail_ff))
      else $error("group retired with no other group queued");

   a_push_live: assert property (@(posedge clock) disable iff (reset)
      q_we |-> (live_ff[q_wdata] || state_ff == FSM_IDLE))
      else $error("a group that is not open was queued");

endmodule
